@@ hw/rtl/dfa_state_minimizer_core_defines.svh @@
// Assertion macros used by the port-level checker file.
`ifndef DFA_STATE_MINIMIZER_CORE_DEFINES_SVH
`define DFA_STATE_MINIMIZER_CORE_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define DSM_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define DSM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

@@ hw/rtl/dsm_pkg.sv @@
// Package with sizes, types and sequencer states of the minimizer.
`timescale 1ns / 1ps
package dsm_pkg;
  localparam int MaxStates  = 32;
  localparam int MaxLetters = 8;
  localparam int SW = $clog2(MaxStates);
  localparam int LW = $clog2(MaxLetters);
  localparam int CW = SW + 1;
  localparam int TDepth = MaxStates * MaxLetters;
  localparam int TW = $clog2(TDepth);

  localparam logic [0:0] REG_STATE_COUNT  = 1'b0;
  localparam logic [0:0] REG_LETTER_COUNT = 1'b1;

  typedef enum logic [13:0] {
    S_LOAD   = 14'b00000000000001,
    S_INIT0  = 14'b00000000000010,
    S_INIT1  = 14'b00000000000100,
    S_CLR    = 14'b00000000001000,
    S_CNT    = 14'b00000000010000,
    S_PFX    = 14'b00000000100000,
    S_PLACE  = 14'b00000001000000,
    S_COPY   = 14'b00000010000000,
    S_CMP    = 14'b00000100000000,
    S_FRESH  = 14'b00001000000000,
    S_NEXT   = 14'b00010000000000,
    S_EMIT   = 14'b00100000000000,
    S_WAIT   = 14'b01000000000000,
    S_KEY    = 14'b10000000000000
  } seq_state_t;
endpackage

@@ hw/rtl/dsm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module dsm_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ hw/rtl/dfa_state_minimizer_core.sv @@
// Top level of the automaton minimizer: table load, refinement sequencer, output.
//
// Transition entries load one per cycle while the block is ready. The entry marked
// s_tlast starts Moore refinement, during which s_tready is low. Refinement walks
// the stores through one shared read port per store, in sub-steps per state access.
// Each round runs (active letter count + 1) sort passes and a renumbering walk over
// the N active states, and at most N rounds run. Then one result per state follows,
// each after a wait state and held while the sink stalls; loading resumes after
// the last result is taken.
`timescale 1ns / 1ps
module dfa_state_minimizer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [5:0]  cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  // tdata: from_state[4:0], symbol[7:5], to_state[12:8], is_accepting[13], zeros
  input  logic [15:0] s_tdata,
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  // tdata: state_index[4:0], class_index[9:5], class_total[15:10]
  output logic [15:0] m_tdata,
  output logic        m_tlast
);
  import dsm_pkg::*;

  logic [5:0] state_count;
  logic [3:0] letter_count;
  seq_state_t st;

  // Active sizes, saturated.
  logic [CW-1:0] n;
  logic [LW:0]   nl;
  always_comb begin
    if (state_count == 6'd0) n = CW'(1);
    else if (state_count > 6'(MaxStates)) n = CW'(MaxStates);
    else n = CW'(state_count);
    if (letter_count == 4'd0) nl = (LW+1)'(1);
    else if (letter_count > 4'(MaxLetters)) nl = (LW+1)'(MaxLetters);
    else nl = (LW+1)'(letter_count);
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state_count  <= 6'd32;
      letter_count <= 4'd2;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_STATE_COUNT:  state_count  <= cfg_data;
        REG_LETTER_COUNT: letter_count <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Stores: transitions, flags, classes (old), sorted, temp, fresh, buckets.
  logic         t_we;  logic [TW-1:0] t_wa, t_ra; logic [SW-1:0] t_wd, t_rd;
  logic         a_we;  logic [SW-1:0] a_wa, a_ra; logic a_wd, a_rd;
  logic         c_we;  logic [SW-1:0] c_wa, c_ra, c_wd, c_rd;
  logic         o_we;  logic [SW-1:0] o_wa, o_ra, o_wd, o_rd;
  logic         p_we;  logic [SW-1:0] p_wa, p_ra, p_wd, p_rd;
  logic         f_we;  logic [SW-1:0] f_wa, f_ra, f_wd, f_rd;
  logic         b_we;  logic [SW-1:0] b_wa, b_ra; logic [CW-1:0] b_wd, b_rd;

  dsm_ram #(.Width(SW), .Depth(TDepth)) u_trans (.clk, .we(t_we), .waddr(t_wa),
    .wdata(t_wd), .raddr(t_ra), .rdata(t_rd));
  dsm_ram #(.Width(1), .Depth(MaxStates)) u_acc (.clk, .we(a_we), .waddr(a_wa),
    .wdata(a_wd), .raddr(a_ra), .rdata(a_rd));
  dsm_ram #(.Width(SW), .Depth(MaxStates)) u_cls (.clk, .we(c_we), .waddr(c_wa),
    .wdata(c_wd), .raddr(c_ra), .rdata(c_rd));
  dsm_ram #(.Width(SW), .Depth(MaxStates)) u_ord (.clk, .we(o_we), .waddr(o_wa),
    .wdata(o_wd), .raddr(o_ra), .rdata(o_rd));
  dsm_ram #(.Width(SW), .Depth(MaxStates)) u_tmp (.clk, .we(p_we), .waddr(p_wa),
    .wdata(p_wd), .raddr(p_ra), .rdata(p_rd));
  dsm_ram #(.Width(SW), .Depth(MaxStates)) u_frs (.clk, .we(f_we), .waddr(f_wa),
    .wdata(f_wd), .raddr(f_ra), .rdata(f_rd));
  dsm_ram #(.Width(CW), .Depth(MaxStates)) u_bkt (.clk, .we(b_we), .waddr(b_wa),
    .wdata(b_wd), .raddr(b_ra), .rdata(b_rd));

  // Sequencer registers.
  logic [CW-1:0] i;          // walk index
  logic [2:0]    ph;         // sub-step within one element
  logic [LW:0]   kind;       // sort pass: letter, or nl for own class
  logic [LW:0]   x;          // letter under compare
  logic          pass_a;     // init: an accepting state was seen
  logic [CW-1:0] pos, run;
  logic [CW-1:0] classes_now, old;
  logic [SW-1:0] cur;
  logic [SW-1:0] q, r, kq, kr, key;
  logic          cmp_b;
  logic [CW-1:0] eidx;

  logic in_acc;
  assign in_acc = s_tvalid && s_tready;
  assign s_tready = (st == S_LOAD);

  logic [SW-1:0] in_from, in_to;
  logic [LW-1:0] in_sym;
  assign in_from = s_tdata[4:0];
  assign in_sym  = s_tdata[7:5];
  assign in_to   = s_tdata[12:8];

  // Destination clamp to the highest active state.
  logic [SW-1:0] t_cl;
  assign t_cl = (CW'(t_rd) >= n) ? SW'(n - CW'(1)) : t_rd;

  // Shared compare: one key against another.
  logic keq;
  assign keq = (kq == kr);

  // Store port control.
  always_comb begin
    t_we = 1'b0; t_wa = {in_from, in_sym}; t_wd = in_to; t_ra = '0;
    a_we = 1'b0; a_wa = in_from; a_wd = s_tdata[13]; a_ra = i[SW-1:0];
    c_we = 1'b0; c_wa = '0; c_wd = '0; c_ra = q;
    o_we = 1'b0; o_wa = pos[SW-1:0]; o_wd = i[SW-1:0]; o_ra = i[SW-1:0];
    p_we = 1'b0; p_wa = '0; p_wd = q; p_ra = i[SW-1:0];
    f_we = 1'b0; f_wa = q; f_wd = cur; f_ra = eidx[SW-1:0];
    b_we = 1'b0; b_wa = key; b_wd = '0; b_ra = key;
    case (st)
      S_LOAD: begin
        t_we = in_acc; a_we = in_acc;
      end
      S_INIT0, S_INIT1: begin
        c_wa = i[SW-1:0]; c_wd = SW'(a_rd);
        c_we = (ph == 3'd1) && (st == S_INIT0);
        o_we = (ph == 3'd1) && (a_rd == (st == S_INIT1));
      end
      S_CLR: begin
        b_we = 1'b1; b_wa = i[SW-1:0]; b_wd = '0;
      end
      S_KEY, S_CNT, S_PLACE: begin
        t_ra = {q, kind[LW-1:0]};
        c_ra = (ph == 3'd3 && kind < nl) ? t_cl : q;
        if (st == S_CNT && ph == 3'd5) begin
          b_we = 1'b1; b_wd = b_rd + CW'(1);
        end
        if (st == S_PLACE && ph == 3'd5) begin
          b_we = 1'b1; b_wd = b_rd + CW'(1);
          p_we = 1'b1; p_wa = b_rd[SW-1:0];
        end
      end
      S_PFX: begin
        b_ra = i[SW-1:0]; b_wa = i[SW-1:0];
        b_we = (ph == 3'd1); b_wd = run;
      end
      S_COPY: begin
        o_we = (ph == 3'd1); o_wa = i[SW-1:0]; o_wd = p_rd;
      end
      S_CMP: begin
        // Read class or destination class of q and r alternately.
        o_ra = i[SW-1:0];
        t_ra = {(cmp_b ? r : q), x[LW-1:0]};
        c_ra = (ph == 3'd4) ? ((x < nl) ? t_cl : (cmp_b ? r : q)) : q;
      end
      S_FRESH: begin
        f_we = 1'b1;
      end
      S_NEXT: begin
        c_we = (ph == 3'd1); c_wa = i[SW-1:0]; c_wd = f_rd;
        f_ra = i[SW-1:0];
      end
      default: ;
    endcase
  end

  // Output register.
  logic [SW-1:0] out_state, out_class;
  assign m_tdata = {classes_now, out_class, out_state};
  assign m_tlast = (CW'(out_state) + CW'(1) == n);

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_LOAD; i <= '0; ph <= '0; m_tvalid <= 1'b0; classes_now <= '0;
      kind <= '0; x <= '0; pos <= '0; pass_a <= 1'b0; cmp_b <= 1'b0; eidx <= '0;
    end else begin
      case (st)
        S_LOAD: begin
          if (in_acc && s_tlast) begin
            st <= S_INIT0; i <= '0; ph <= '0; pos <= '0; pass_a <= 1'b0; old <= '0;
          end
        end
        S_INIT0, S_INIT1: begin
          // ph0 issue flag read, ph1 write class/order.
          if (ph == 3'd0) ph <= 3'd1;
          else begin
            ph <= 3'd0;
            if (a_rd == (st == S_INIT1)) pos <= pos + CW'(1);
            if (st == S_INIT0 && a_rd) pass_a <= 1'b1;
            if (st == S_INIT0 && !a_rd) old[0] <= 1'b1;
            if (i + CW'(1) == n) begin
              i <= '0;
              if (st == S_INIT0) st <= S_INIT1;
              else begin
                classes_now <= CW'(old[0]) + CW'(pass_a);
                kind <= '0; st <= S_CLR;
              end
            end else i <= i + CW'(1);
          end
        end
        S_CLR: begin
          if (i == CW'(MaxStates - 1)) begin
            i <= '0; ph <= '0; st <= S_CNT;
          end else i <= i + CW'(1);
        end
        S_CNT, S_PLACE: begin
          // ph0 read order, ph1 take q, ph2 read trans, ph3 read class or
          // dest class, ph4 key, ph6 bucket read, ph5 bucket update.
          case (ph)
            3'd0: ph <= 3'd1;
            3'd1: begin q <= o_rd; ph <= 3'd2; end
            3'd2: ph <= 3'd3;
            3'd3: ph <= 3'd4;
            3'd4: begin key <= c_rd; ph <= 3'd6; end
            3'd6: ph <= 3'd5;
            default: begin
              ph <= 3'd0;
              if (i + CW'(1) == n) begin
                i <= '0;
                if (st == S_CNT) begin st <= S_PFX; run <= '0; end
                else st <= S_COPY;
              end else i <= i + CW'(1);
            end
          endcase
        end
        S_PFX: begin
          if (ph == 3'd0) ph <= 3'd1;
          else if (ph == 3'd1) begin
            ph <= 3'd0; run <= run + b_rd;
            if (i == CW'(MaxStates - 1)) begin i <= '0; st <= S_PLACE; end
            else i <= i + CW'(1);
          end
        end
        S_COPY: begin
          if (ph == 3'd0) ph <= 3'd1;
          else begin
            ph <= 3'd0;
            if (i + CW'(1) == n) begin
              i <= '0;
              if (kind == nl) begin
                kind <= '0; old <= classes_now; cur <= '0;
                q <= '0; st <= S_CMP; ph <= 3'd0; x <= nl; cmp_b <= 1'b0;
              end else begin kind <= kind + (LW+1)'(1); st <= S_CLR; end
            end else i <= i + CW'(1);
          end
        end
        S_CMP: begin
          // Walk sorted order; i is the current position.
          case (ph)
            3'd0: ph <= 3'd1;
            3'd1: ph <= 3'd2;
            3'd2: begin
              r <= q; q <= o_rd; x <= nl; cmp_b <= 1'b0;
              if (i == '0) st <= S_FRESH;
              else ph <= 3'd3;
            end
            3'd3: ph <= 3'd4;
            3'd4: ph <= 3'd5;
            3'd5: begin
              if (cmp_b) begin
                kr <= c_rd; ph <= 3'd6;
              end else begin
                kq <= c_rd; cmp_b <= 1'b1; ph <= 3'd3;
              end
            end
            default: begin
              cmp_b <= 1'b0;
              if (!keq) begin cur <= cur + SW'(1); st <= S_FRESH; end
              else if (x == '0) st <= S_FRESH;
              else begin x <= x - (LW+1)'(1); ph <= 3'd3; end
            end
          endcase
        end
        S_FRESH: begin
          ph <= 3'd0;
          if (i + CW'(1) == n) begin i <= '0; st <= S_NEXT; end
          else begin i <= i + CW'(1); st <= S_CMP; end
        end
        S_NEXT: begin
          if (ph == 3'd0) ph <= 3'd1;
          else begin
            ph <= 3'd0;
            if (i + CW'(1) == n) begin
              i <= '0;
              classes_now <= CW'(cur) + CW'(1);
              if (CW'(cur) + CW'(1) > old) st <= S_CLR;
              else begin st <= S_WAIT; eidx <= '0; end
            end else i <= i + CW'(1);
          end
        end
        S_WAIT: begin
          // Fresh store holds final classes; read ahead one entry.
          if (!m_tvalid || m_tready) st <= S_EMIT;
        end
        S_EMIT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1; out_state <= eidx[SW-1:0]; out_class <= f_rd;
            if (eidx + CW'(1) == n) st <= S_KEY;
            else begin eidx <= eidx + CW'(1); st <= S_WAIT; end
          end
        end
        S_KEY: begin
          // Drain the last result, then resume loading.
          if (m_tready) begin m_tvalid <= 1'b0; st <= S_LOAD; end
        end
        default: st <= S_LOAD;
      endcase
      if (st != S_EMIT && st != S_KEY && m_tvalid && m_tready) m_tvalid <= 1'b0;
    end
  end
endmodule

@@ hw/rtl/dsm_checker.sv @@
// Port-level checker for the minimizer, bound to the top level.
`timescale 1ns / 1ps
`include "dfa_state_minimizer_core_defines.svh"
module dsm_assertions (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic        m_tlast
);
  // Results never overlap loading.
  `DSM_ASSERT_IMP(a_no_overlap, clk, rst, m_tvalid, !s_tready)
  // A stalled result holds.
  `DSM_ASSERT_NEXT(a_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  // Class index is below class total.
  `DSM_ASSERT_IMP(a_cls, clk, rst, m_tvalid, {1'b0, m_tdata[9:5]} < m_tdata[15:10])
  // After the last result is taken, loading resumes.
  `DSM_ASSERT_NEXT(a_resume, clk, rst, m_tvalid && m_tready && m_tlast, s_tready)
endmodule

bind dfa_state_minimizer_core dsm_assertions u_dsm_assertions (.*);

@@ verif/dsm_checker.sv @@
// Checker for the minimizer: watches both streams, predicts class results and compares them.
`timescale 1ns / 1ps
module dsm_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [5:0]  cfg_data,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [15:0] s_tdata,
  input  logic        s_tlast,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,
  input  logic        m_tlast,
  output int          errors,
  output int          pending
);
  import dsm_pkg::*;

  typedef struct packed {
    logic [4:0] state_index;
    logic [4:0] class_index;
    logic [5:0] class_total;
    logic       last_result;
  } class_result_t;

  class_result_t expected_classes[$];

  // Shadow copy of the automaton stores and the registers.
  logic [4:0] trans_shadow [TDepth];
  logic       accept_shadow [MaxStates];
  logic [4:0] class_shadow [MaxStates];
  logic [4:0] order_shadow [MaxStates];
  logic [5:0] state_count_q;
  logic [3:0] letter_count_q;
  int         results_seen;

  assign pending = expected_classes.size();

  function automatic int dest_class_of(int q, int x, int n);
    int t;
    t = trans_shadow[q * MaxLetters + x];
    if (t >= n) t = n - 1;
    return class_shadow[t];
  endfunction

  function automatic int key_of(int q, int kind, int n, int nl);
    if (kind < nl) return dest_class_of(q, kind, n);
    return class_shadow[q];
  endfunction

  // One stable counting sort of the state order by the given key.
  function automatic void bucket_sort(int kind, int n, int nl);
    int bc [MaxStates];
    logic [4:0] tmp [MaxStates];
    int run, c, k, q;
    run = 0;
    for (int i = 0; i < MaxStates; i++) bc[i] = 0;
    for (int i = 0; i < n; i++) bc[key_of(order_shadow[i], kind, n, nl) % MaxStates]++;
    for (int i = 0; i < MaxStates; i++) begin
      c = bc[i];
      bc[i] = run;
      run += c;
    end
    for (int i = 0; i < n; i++) begin
      q = order_shadow[i];
      k = key_of(q, kind, n, nl) % MaxStates;
      tmp[bc[k] % MaxStates] = q[4:0];
      bc[k]++;
    end
    for (int i = 0; i < n; i++) order_shadow[i] = tmp[i];
  endfunction

  function automatic bit neighbors_differ(int q, int r, int n, int nl);
    if (class_shadow[q] != class_shadow[r]) return 1'b1;
    for (int x = 0; x < nl; x++)
      if (dest_class_of(q, x, n) != dest_class_of(r, x, n)) return 1'b1;
    return 1'b0;
  endfunction

  // Moore refinement over the shadow stores; returns the final class count.
  function automatic int refine_classes(int n, int nl);
    logic [4:0] fresh [MaxStates];
    int pos, has0, has1, total, prev, cur;
    pos = 0; has0 = 0; has1 = 0;
    for (int i = 0; i < n; i++) begin
      class_shadow[i] = {4'd0, accept_shadow[i]};
      if (accept_shadow[i]) has1 = 1; else has0 = 1;
    end
    for (int i = 0; i < n; i++) if (!accept_shadow[i]) order_shadow[pos++] = i[4:0];
    for (int i = 0; i < n; i++) if (accept_shadow[i]) order_shadow[pos++] = i[4:0];
    total = has0 + has1;
    forever begin
      prev = total;
      cur = 0;
      for (int x = 0; x <= nl; x++) bucket_sort(x, n, nl);
      fresh[order_shadow[0]] = 5'd0;
      for (int i = 1; i < n; i++) begin
        if (neighbors_differ(order_shadow[i - 1], order_shadow[i], n, nl)) cur++;
        fresh[order_shadow[i]] = cur[4:0];
      end
      for (int i = 0; i < n; i++) class_shadow[i] = fresh[i];
      total = cur + 1;
      if (!(total > prev)) break;
    end
    return total;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
    errors++;
  endtask

  // Track register writes, accepted entries and accepted results.
  always @(posedge clk) begin
    int n, nl, total;
    class_result_t r, w;
    if (rst) begin
      state_count_q <= 6'd32;
      letter_count_q <= 4'd2;
      errors = 0;
      results_seen = 0;
      expected_classes.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_STATE_COUNT) state_count_q <= cfg_data;
        else if (cfg_index == REG_LETTER_COUNT) letter_count_q <= cfg_data[3:0];
      end
      if (s_tvalid && s_tready) begin
        trans_shadow[{s_tdata[4:0], s_tdata[7:5]}] = s_tdata[12:8];
        accept_shadow[s_tdata[4:0]] = s_tdata[13];
        if (s_tlast) begin
          n = (state_count_q == 0) ? 1 : (state_count_q > MaxStates ? MaxStates : state_count_q);
          nl = (letter_count_q == 0) ? 1 :
               (letter_count_q > MaxLetters ? MaxLetters : letter_count_q);
          total = refine_classes(n, nl);
          for (int i = 0; i < n; i++) begin
            w.state_index = i[4:0];
            w.class_index = class_shadow[i];
            w.class_total = total[5:0];
            w.last_result = (i + 1 == n);
            expected_classes.push_back(w);
          end
        end
      end
      if (m_tvalid && m_tready) begin
        r = {m_tdata[4:0], m_tdata[9:5], m_tdata[15:10], m_tlast};
        results_seen++;
        if (expected_classes.size() == 0) begin
          report_mismatch("unexpected result, state_index", r.state_index, -1);
        end else begin
          w = expected_classes.pop_front();
          if (r.state_index != w.state_index)
            report_mismatch("state_index", r.state_index, w.state_index);
          if (r.class_index != w.class_index)
            report_mismatch("class_index", r.class_index, w.class_index);
          if (r.class_total != w.class_total)
            report_mismatch("class_total", r.class_total, w.class_total);
          if (r.last_result != w.last_result)
            report_mismatch("last_result", r.last_result, w.last_result);
        end
      end
    end
  end
endmodule

@@ verif/tb_top.sv @@
// Testbench top for the minimizer: drives automata and registers, gives the verdict.
`timescale 1ns / 1ps
module tb_top;
  import dsm_pkg::*;

  localparam int CycleLimit = 20000000;
  localparam int ItemTarget = 420;

  logic        clk, rst;
  logic        cfg_we;
  logic [0:0]  cfg_index;
  logic [5:0]  cfg_data;
  logic        s_tvalid, s_tready, s_tlast;
  logic [15:0] s_tdata;
  logic        m_tvalid, m_tready, m_tlast;
  logic [15:0] m_tdata;
  int          errors, pending;
  int          cycles, entries_sent, automata_sent;
  bit          hold_req, steady;
  bit          loaded [TDepth];
  int          n_act, nl_act;

  dfa_state_minimizer_core dut (.*);
  dsm_checker chk (.*);

  // Free-running clock.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run limit.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  // Result sink: random stalls, a long hold-off on request, steady stretches.
  initial begin
    int r;
    m_tready = 1'b0;
    forever begin
      r = $urandom_range(0, 99);
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (600) @(posedge clk);
      end else if (steady || r < 60) begin
        m_tready <= 1'b1;
        @(posedge clk);
      end else if (r < 95) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        m_tready <= 1'b0;
        repeat ($urandom_range(10, 40)) @(posedge clk);
      end
    end
  end

  task automatic write_reg(logic [0:0] idx, logic [5:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Waits until the block is idle, then sets both registers.
  task automatic set_shape(logic [5:0] sc, logic [3:0] lc);
    wait (pending == 0);
    repeat (8) @(posedge clk);
    write_reg(REG_STATE_COUNT, sc);
    write_reg(REG_LETTER_COUNT, {2'b00, lc});
    n_act = (sc == 0) ? 1 : (sc > MaxStates ? MaxStates : sc);
    nl_act = (lc == 0) ? 1 : (lc > MaxLetters ? MaxLetters : lc);
  endtask

  // One entry transaction, followed by an optional gap.
  task automatic send_entry(int from, int sym, int to, bit acc, bit last);
    int r;
    s_tdata <= {2'b00, acc, to[4:0], sym[2:0], from[4:0]};
    s_tlast <= last;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    loaded[from * MaxLetters + sym] = 1'b1;
    entries_sent++;
    r = $urandom_range(0, 99);
    if (last) begin
      // The final entry is taken once; stop offering it.
      s_tvalid <= 1'b0;
      @(posedge clk);
    end else if (!steady && r >= 55) begin
      s_tvalid <= 1'b0;
      repeat (r < 95 ? $urandom_range(1, 3) : $urandom_range(10, 30)) @(posedge clk);
    end
  endtask

  // Loads one automaton: every active entry not yet written plus random rewrites,
  // some noise entries, then a final entry that starts refinement.
  // acc_mode: 0 random flags, 1 all accepting, 2 none accepting.
  task automatic send_automaton(int acc_mode, bit noisy, bit hold);
    bit acc_of [MaxStates];
    int fs, fx;
    for (int s = 0; s < MaxStates; s++)
      acc_of[s] = (acc_mode == 1) ? 1'b1 : (acc_mode == 2) ? 1'b0 : 1'($urandom);
    for (int s = 0; s < n_act; s++)
      for (int x = 0; x < nl_act; x++) begin
        if (!loaded[s * MaxLetters + x] || $urandom_range(0, 99) < 25)
          send_entry(s, x, $urandom_range(0, 31), acc_of[s], 1'b0);
        if (noisy && $urandom_range(0, 99) < 10)
          send_entry($urandom_range(0, 31), $urandom_range(0, 7), $urandom_range(0, 31),
                     1'($urandom), 1'b0);
      end
    fs = $urandom_range(0, n_act - 1);
    fx = $urandom_range(0, nl_act - 1);
    if (hold) hold_req = 1'b1;
    send_entry(fs, fx, $urandom_range(0, 31), acc_of[fs], 1'b1);
    automata_sent++;
  endtask

  initial begin
    int r;
    rst = 1'b1;
    cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    s_tvalid = 1'b0; s_tdata = '0; s_tlast = 1'b0;
    hold_req = 1'b0; steady = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: saturated registers, single-class automata, widest alphabet.
    set_shape(6'd0, 4'd0);
    send_automaton(0, 1'b0, 1'b0);
    set_shape(6'd2, 4'd15);
    send_automaton(2, 1'b0, 1'b0);
    set_shape(6'd5, 4'd8);
    send_automaton(1, 1'b0, 1'b1);
    send_automaton(0, 1'b0, 1'b0);
    set_shape(6'd63, 4'd1);
    send_automaton(1, 1'b0, 1'b0);

    // Random automata, mostly small; the block is kept busy across loads.
    while (entries_sent < ItemTarget) begin
      r = $urandom_range(0, 99);
      steady = ($urandom_range(0, 99) < 15);
      if (r < 8) set_shape(6'd32, 4'($urandom_range(1, 2)));
      else if (r < 14) set_shape(6'($urandom_range(1, 3)), 4'($urandom_range(8, 15)));
      else if (r < 60) set_shape(6'($urandom_range(1, 10)), 4'($urandom_range(1, 4)));
      send_automaton($urandom_range(0, 9) == 0 ? 1 + $urandom_range(0, 1) : 0,
                     $urandom_range(0, 99) < 50, $urandom_range(0, 99) < 5);
    end
    steady = 1'b0;

    wait (pending == 0);
    repeat (200) @(posedge clk);
    $display("Loaded %0d automata from %0d entries, widths 1..32 states and 1..8 letters.",
             automata_sent, entries_sent);
    $display("Checked %0d class results with random stalls on both streams.",
             chk.results_seen);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
